// ===== design/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types, sizes, codes and the quarter-wave sine table of the turtle
// command engine.
// ----------------------------------------------------------------------------
package tce_pkg;

    // stack of saved turtle states
    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

    // sine table: steps of a full turn, a multiple of four
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
    localparam int HALF_TURN        = SINE_TABLE_DEPTH / 2;
    localparam int QUARTER_TURN     = SINE_TABLE_DEPTH / 4;
    localparam int Q_W              = $clog2(QUARTER_TURN + 1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [15:0] HEADING_RESET = 16'd16384;
    localparam logic [11:0] LENGTH_RESET  = 12'd10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 2'd0,
        CFG_START_Y = 2'd1,
        CFG_INIT_LEN = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        REQ_DRAW   = 3'd0,
        REQ_MOVE   = 3'd1,
        REQ_TURN   = 3'd2,
        REQ_SETLEN = 3'd3,
        REQ_PUSH   = 3'd4,
        REQ_POP    = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOOKUP,
        PH_FINISH
    } phase_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic        [15:0] heading;
        logic        [11:0] len;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef logic [14:0] sin_tab_t [0:QUARTER_TURN];

    // unsigned Q1.14 sine magnitudes over a quarter turn, from a Taylor series in Q2.30
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t    tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        longint      sum;
        for (int q = 0; q <= QUARTER_TURN; q++) begin
            x    = (HALF_PI_Q30 * 64'(4 * q)) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            mag = (64'(sum) + 64'd32768) >> 16;
            if (mag > 64'd16384)
                mag = 64'd16384;
            tab[q] = 15'(mag);
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    // signed Q2.14 sine of table step idx
    function automatic logic signed [15:0] sine_val(input logic [IDX_W-1:0] idx);
        logic             neg;
        logic [IDX_W-1:0] i2;
        logic [IDX_W-1:0] q;
        logic [15:0]      mag;
        neg = (idx >= IDX_W'(HALF_TURN));
        i2  = neg ? idx - IDX_W'(HALF_TURN) : idx;
        q   = (i2 > IDX_W'(QUARTER_TURN)) ? IDX_W'(HALF_TURN) - i2 : i2;
        mag = 16'(SIN_TAB[q[Q_W-1:0]]);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    // divide a Q.14 sum by 16384 towards zero and clamp to 16-bit signed
    function automatic logic signed [15:0] trunc_sat(input logic signed [30:0] v);
        logic signed [30:0] adj;
        logic signed [16:0] q;
        adj = v + (v[30] ? 31'sd16383 : 31'sd0);
        q   = adj[30:14];
        if (q > 17'sd32767)
            return 16'sh7fff;
        else if (q < -17'sd32768)
            return 16'sh8000;
        else
            return q[15:0];
    endfunction

endpackage

// ===== design/tce_ram.sv =====
// ----------------------------------------------------------------------------
// tce_ram
// Generic single-clock RAM, one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/tce_step.sv =====
// ----------------------------------------------------------------------------
// tce_step
// Position step: sine/cosine lookup and length multiply before the product register,
// add, truncate and saturate after it.
// ----------------------------------------------------------------------------
module tce_step
    import tce_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  logic [15:0]        heading,
    input  logic [11:0]        len,
    input  logic signed [15:0] x,
    input  logic signed [15:0] y,
    output logic signed [15:0] new_x,
    output logic signed [15:0] new_y
);

    logic [16+IDX_W-1:0] hprod;
    logic [IDX_W-1:0]    sin_idx;
    logic [IDX_W:0]      cos_sum;
    logic [IDX_W-1:0]    cos_idx;
    logic signed [15:0]  sin_v;
    logic signed [15:0]  cos_v;
    logic signed [12:0]  len_s;
    logic signed [28:0]  prod_c_next;
    logic signed [28:0]  prod_s_next;
    logic signed [28:0]  prod_c_reg;
    logic signed [28:0]  prod_s_reg;
    logic signed [30:0]  sum_x;
    logic signed [30:0]  sum_y;

    always_comb
    begin
        hprod   = (16+IDX_W)'(heading) * (16+IDX_W)'(SINE_TABLE_DEPTH);
        sin_idx = hprod[16 +: IDX_W];
        // cosine is a quarter turn ahead
        cos_sum = {1'b0, sin_idx} + (IDX_W+1)'(QUARTER_TURN);
        if (cos_sum >= (IDX_W+1)'(SINE_TABLE_DEPTH))
            cos_idx = IDX_W'(cos_sum - (IDX_W+1)'(SINE_TABLE_DEPTH));
        else
            cos_idx = cos_sum[IDX_W-1:0];
        sin_v       = sine_val(sin_idx);
        cos_v       = sine_val(cos_idx);
        len_s       = $signed({1'b0, len});
        prod_c_next = 29'(len_s) * 29'(cos_v);
        prod_s_next = 29'(len_s) * 29'(sin_v);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_c_reg <= prod_c_next;
            prod_s_reg <= prod_s_next;
        end
    end

    always_comb
    begin
        sum_x = (31'(x) <<< 14) + 31'(prod_c_reg);
        sum_y = (31'(y) <<< 14) - 31'(prod_s_reg);
        new_x = trunc_sat(sum_x);
        new_y = trunc_sat(sum_y);
    end

endmodule

// ===== design/tce_ctrl.sv =====
// ----------------------------------------------------------------------------
// tce_ctrl
// Sequencer: lookup phase then finish phase per word, finish waits for room
// in the output register.
// ----------------------------------------------------------------------------
module tce_ctrl
    import tce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_full,
    input  logic  out_ready,
    output ctrl_t ctrl
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   can_finish;

    assign can_finish = !out_full || out_ready;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_valid)
                    phase_next = PH_LOOKUP;
            end
            PH_LOOKUP:
            begin
                phase_next = PH_FINISH;
            end
            PH_FINISH:
            begin
                if (can_finish)
                    phase_next = in_valid ? PH_LOOKUP : PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            PH_LOOKUP:
            begin
                ctrl.load = 1'b1;
            end
            PH_FINISH:
            begin
                ctrl.finish   = can_finish;
                ctrl.in_ready = can_finish;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

endmodule

// ===== design/turtle_command_engine.sv =====
// ----------------------------------------------------------------------------
// turtle_command_engine
// Turtle graphics command interpreter with a saved-state stack.
// ----------------------------------------------------------------------------
// One word is taken at a time: the lookup phase looks up sine and cosine and
// multiplies them by the step length (and reads the stack memory for a pop),
// the finish phase adds, saturates and writes the turtle state back, so each
// word sees the state left by the one before. One result word comes out for
// every command word; it sits in an output register, and the next command is
// taken while it waits. The stack memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module turtle_command_engine
    import tce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            req_type,
    input  logic signed [15:0]    turn_amount,
    input  logic [11:0]           new_length,
    input  logic [23:0]           line_color,
    input  logic [7:0]            line_thickness,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [15:0]    seg_x0,
    output logic signed [15:0]    seg_y0,
    output logic signed [15:0]    seg_x1,
    output logic signed [15:0]    seg_y1,
    output logic [23:0]           seg_color,
    output logic [7:0]            seg_thickness,
    output logic                  seg_valid,
    output logic [1:0]            status
);

    ctrl_t ctrl;
    logic  accept;

    // captured command word
    req_t        req_reg;
    logic [15:0] turn_reg;
    logic [11:0] length_reg;
    logic [23:0] color_reg;
    logic [7:0]  thick_reg;

    // turtle state
    logic [15:0]        heading_reg;
    logic [11:0]        len_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [15:0]        heading_next;
    logic [11:0]        len_next;
    logic signed [15:0] x_next;
    logic signed [15:0] y_next;
    logic [COUNT_W-1:0] count_next;

    // output register
    logic               out_valid_reg;
    logic signed [15:0] seg_x0_reg;
    logic signed [15:0] seg_y0_reg;
    logic signed [15:0] seg_x1_reg;
    logic signed [15:0] seg_y1_reg;
    logic [23:0]        seg_color_reg;
    logic [7:0]         seg_thick_reg;
    logic               seg_valid_reg;
    status_t            status_reg;
    logic signed [15:0] seg_x0_next;
    logic signed [15:0] seg_y0_next;
    logic signed [15:0] seg_x1_next;
    logic signed [15:0] seg_y1_next;
    logic [23:0]        seg_color_next;
    logic [7:0]         seg_thick_next;
    logic               seg_valid_next;
    status_t            status_next;

    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
    logic               stack_we;
    logic [COUNT_W-1:0] count_dec;
    logic [STACK_AW-1:0] stack_raddr;
    entry_t             push_entry;
    entry_t             pop_entry;
    logic [ENTRY_W-1:0] pop_word;

    tce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_full  (out_valid_reg),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    tce_step u_step (
        .clk     (clk),
        .load    (ctrl.load),
        .heading (heading_reg),
        .len     (len_reg),
        .x       (x_reg),
        .y       (y_reg),
        .new_x   (step_x),
        .new_y   (step_y)
    );

    // top of stack is read every cycle; count only moves on finish
    assign count_dec   = count_reg - COUNT_W'(1);
    assign stack_raddr = count_dec[STACK_AW-1:0];
    assign push_entry  = '{heading: heading_reg, len: len_reg, x: x_reg, y: y_reg};
    assign pop_entry   = entry_t'(pop_word);

    tce_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (count_reg[STACK_AW-1:0]),
        .wdata (push_entry),
        .raddr (stack_raddr),
        .rdata (pop_word)
    );

    assign in_ready = ctrl.in_ready;
    assign accept   = in_valid && ctrl.in_ready;

    always_comb
    begin
        heading_next   = heading_reg;
        len_next       = len_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        count_next     = count_reg;
        stack_we       = 1'b0;
        seg_x0_next    = '0;
        seg_y0_next    = '0;
        seg_x1_next    = '0;
        seg_y1_next    = '0;
        seg_color_next = '0;
        seg_thick_next = '0;
        seg_valid_next = 1'b0;
        status_next    = STAT_OK;
        case (req_reg)
            REQ_DRAW:
            begin
                x_next         = step_x;
                y_next         = step_y;
                seg_x0_next    = x_reg;
                seg_y0_next    = y_reg;
                seg_x1_next    = step_x;
                seg_y1_next    = step_y;
                seg_color_next = color_reg;
                seg_thick_next = thick_reg;
                seg_valid_next = 1'b1;
            end
            REQ_MOVE:
            begin
                x_next = step_x;
                y_next = step_y;
            end
            REQ_TURN:
            begin
                heading_next = heading_reg + turn_reg;
            end
            REQ_SETLEN:
            begin
                len_next = length_reg;
            end
            REQ_PUSH:
            begin
                if (count_reg == COUNT_W'(STACK_DEPTH))
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    stack_we   = ctrl.finish;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            REQ_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    heading_next = pop_entry.heading;
                    len_next     = pop_entry.len;
                    x_next       = pop_entry.x;
                    y_next       = pop_entry.y;
                    count_next   = count_dec;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_t'(req_type);
            turn_reg   <= turn_amount;
            length_reg <= new_length;
            color_reg  <= line_color;
            thick_reg  <= line_thickness;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg <= HEADING_RESET;
            len_reg     <= LENGTH_RESET;
            x_reg       <= '0;
            y_reg       <= '0;
            count_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_X:  x_reg   <= cfg_data[15:0];
                CFG_START_Y:  y_reg   <= cfg_data[15:0];
                CFG_INIT_LEN: len_reg <= cfg_data[11:0];
                default:      len_reg <= len_reg;
            endcase
        end
        else if (ctrl.finish)
        begin
            heading_reg <= heading_next;
            len_reg     <= len_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            seg_x0_reg    <= seg_x0_next;
            seg_y0_reg    <= seg_y0_next;
            seg_x1_reg    <= seg_x1_next;
            seg_y1_reg    <= seg_y1_next;
            seg_color_reg <= seg_color_next;
            seg_thick_reg <= seg_thick_next;
            seg_valid_reg <= seg_valid_next;
            status_reg    <= status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign seg_x0        = seg_x0_reg;
    assign seg_y0        = seg_y0_reg;
    assign seg_x1        = seg_x1_reg;
    assign seg_y1        = seg_y1_reg;
    assign seg_color     = seg_color_reg;
    assign seg_thickness = seg_thick_reg;
    assign seg_valid     = seg_valid_reg;
    assign status        = status_reg;

endmodule

// ===== tb/turtle_command_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// turtle_command_engine_tb
// Self-checking bench for the turtle command engine. Commands go in over a
// valid/ready channel with random gaps; result words come back with random
// stalls. A small tracker keeps its own turtle state and saved-state stack,
// works out every result word, and checks each returned word field by field.
// Runs a directed opening, a stack fill and drain, then random command
// streams under several start positions and step lengths.
// ----------------------------------------------------------------------------
module turtle_command_engine_tb;
    import tce_pkg::*;

    localparam int STACK_LIMIT = 64;
    localparam int TABLE_STEPS = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [23:0]        color;
        logic [7:0]         thick;
        logic               drawn;
        status_t            st;
    } seg_word_t;

    typedef struct {
        logic [15:0] heading;
        logic [11:0] len;
        int          x;
        int          y;
    } pose_t;

    class turtle_tracker;
        pose_t     here;
        pose_t     saved [STACK_LIMIT];
        int        depth;
        seg_word_t segments_due [$];
        int        errors;
        int        words_noted;
        int        words_checked;
        int        draws;
        int        clipped;
        int        full_pushes;
        int        empty_pops;

        function new();
            errors        = 0;
            words_noted   = 0;
            words_checked = 0;
            draws         = 0;
            clipped       = 0;
            full_pushes   = 0;
            empty_pops    = 0;
            depth         = 0;
            here.heading  = 16'd16384;
            here.len      = 12'd10;
            here.x        = 0;
            here.y        = 0;
        endfunction

        function void configure(cfg_reg_t idx, logic [15:0] val);
            case (idx)
                CFG_START_X:  here.x = int'($signed(val));
                CFG_START_Y:  here.y = int'($signed(val));
                CFG_INIT_LEN: here.len = val[11:0];
                default: ;
            endcase
        endfunction

        // q2.14 sine of a quarter-resolution angle u in [0, 4*steps)
        function int table_sine(int unsigned u);
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned mag;
            longint          sum;
            bit              neg;
            neg = 1'b0;
            if (u >= 2 * TABLE_STEPS)
            begin
                neg = 1'b1;
                u   = u - 2 * TABLE_STEPS;
            end
            if (u > TABLE_STEPS)
                u = 2 * TABLE_STEPS - u;
            x    = (HALF_PI_Q30 * u) / TABLE_STEPS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 8; k++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            mag = (longint'(sum) + 64'd32768) >> 16;
            if (mag > 64'd16384)
                mag = 64'd16384;
            return neg ? -int'(mag) : int'(mag);
        endfunction

        function int clamp16(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return int'(v);
        endfunction

        // one step along the heading, truncated toward zero then clamped
        function void step_turtle();
            int unsigned idx;
            int          s;
            int          c;
            longint      nx;
            longint      ny;
            idx = (int'(here.heading) * TABLE_STEPS) >> 16;
            s   = table_sine(4 * idx);
            c   = table_sine((4 * idx + TABLE_STEPS) % (4 * TABLE_STEPS));
            nx  = longint'(here.x) * 16384 + longint'(here.len) * c;
            ny  = longint'(here.y) * 16384 - longint'(here.len) * s;
            nx  = nx / 16384;
            ny  = ny / 16384;
            if (nx > 32767 || nx < -32768 || ny > 32767 || ny < -32768)
                clipped++;
            here.x = clamp16(nx);
            here.y = clamp16(ny);
        endfunction

        function void note_command(logic [2:0] req, logic [15:0] turn,
                                   logic [11:0] len, logic [23:0] color,
                                   logic [7:0] thick);
            seg_word_t w;
            w.x0    = '0;
            w.y0    = '0;
            w.x1    = '0;
            w.y1    = '0;
            w.color = '0;
            w.thick = '0;
            w.drawn = 1'b0;
            w.st    = STAT_OK;
            words_noted++;
            case (req)
                REQ_DRAW:
                begin
                    w.x0 = here.x[15:0];
                    w.y0 = here.y[15:0];
                    step_turtle();
                    w.x1    = here.x[15:0];
                    w.y1    = here.y[15:0];
                    w.color = color;
                    w.thick = thick;
                    w.drawn = 1'b1;
                    draws++;
                end
                REQ_MOVE:   step_turtle();
                REQ_TURN:   here.heading = here.heading + turn;
                REQ_SETLEN: here.len = len;
                REQ_PUSH:
                begin
                    if (depth >= STACK_LIMIT)
                    begin
                        w.st = STAT_FULL;
                        full_pushes++;
                    end
                    else
                    begin
                        saved[depth] = here;
                        depth++;
                    end
                end
                REQ_POP:
                begin
                    if (depth == 0)
                    begin
                        w.st = STAT_EMPTY;
                        empty_pops++;
                    end
                    else
                    begin
                        depth--;
                        here = saved[depth];
                    end
                end
                default: ;
            endcase
            segments_due.push_back(w);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at result word %0d: %s", words_checked, what);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, want %0h", name, got, want));
        endtask

        task check_result(seg_word_t got);
            seg_word_t want;
            if (segments_due.size() == 0)
            begin
                report("result word with no command waiting");
            end
            else
            begin
                want = segments_due[0];
                segments_due.delete(0);
                compare_field("seg_x0", got.x0, want.x0);
                compare_field("seg_y0", got.y0, want.y0);
                compare_field("seg_x1", got.x1, want.x1);
                compare_field("seg_y1", got.y1, want.y1);
                compare_field("seg_color", got.color, want.color);
                compare_field("seg_thickness", got.thick, want.thick);
                compare_field("seg_valid", got.drawn, want.drawn);
                compare_field("status", got.st, want.st);
            end
            words_checked++;
        endtask

        task finish_up();
            if (segments_due.size() != 0)
                report($sformatf("%0d result words never arrived", segments_due.size()));
        endtask
    endclass

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic [2:0]            req_type       = '0;
    logic signed [15:0]    turn_amount    = '0;
    logic [11:0]           new_length     = '0;
    logic [23:0]           line_color     = '0;
    logic [7:0]            line_thickness = 8'd1;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic signed [15:0]    seg_x0;
    logic signed [15:0]    seg_y0;
    logic signed [15:0]    seg_x1;
    logic signed [15:0]    seg_y1;
    logic [23:0]           seg_color;
    logic [7:0]            seg_thickness;
    logic                  seg_valid;
    logic [1:0]            status;

    bit            gaps_on   = 1'b1;
    bit            stalls_on = 1'b1;
    bit            quiet     = 1'b0;
    int            cycles    = 0;
    turtle_tracker tracker   = new();

    turtle_command_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .turn_amount    (turn_amount),
        .new_length     (new_length),
        .line_color     (line_color),
        .line_thickness (line_thickness),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .seg_x0         (seg_x0),
        .seg_y0         (seg_y0),
        .seg_x1         (seg_x1),
        .seg_y1         (seg_y1),
        .seg_color      (seg_color),
        .seg_thickness  (seg_thickness),
        .seg_valid      (seg_valid),
        .status         (status)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycles);
            $display("turtle_command_engine test failed");
            $finish;
        end
    end

    // result side: check accepted words, then pick next ready
    initial
    begin : result_side
        seg_word_t got;
        int        stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.x0    = seg_x0;
                got.y0    = seg_y0;
                got.x1    = seg_x1;
                got.y1    = seg_y1;
                got.color = seg_color;
                got.thick = seg_thickness;
                got.drawn = seg_valid;
                got.st    = status_t'(status);
                tracker.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [2:0] req, input logic [15:0] turn,
                             input logic [11:0] len, input logic [23:0] color,
                             input logic [7:0] thick);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= req;
        turn_amount    <= turn;
        new_length     <= len;
        line_color     <= color;
        line_thickness <= thick;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_command(req, turn, len, color, thick);
    endtask

    task automatic send_op(input logic [2:0] req, input logic [11:0] len);
        send_word(req, 16'($urandom), len, 24'($urandom), 8'($urandom_range(1, 255)));
    endtask

    // hold the sender off until every result word is back
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.segments_due.size() != 0);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.configure(idx, val);
    endtask

    task automatic program_start(input logic [15:0] sx, input logic [15:0] sy,
                                 input logic [11:0] len0);
        write_register(CFG_START_X, sx);
        write_register(CFG_START_Y, sy);
        write_register(CFG_INIT_LEN, {4'b0, len0});
        cfg_we <= 1'b0;
    endtask

    task automatic random_run(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            if (!quiet && i % 50 == 0)
            begin
                gaps_on   = $urandom_range(0, 3) != 0;
                stalls_on = $urandom_range(0, 3) != 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 34)
                send_op(REQ_DRAW, 12'($urandom));
            else if (pick < 48)
                send_op(REQ_MOVE, 12'($urandom));
            else if (pick < 66)
                send_op(REQ_TURN, 12'($urandom));
            else if (pick < 76)
                // mostly short steps so the turtle wanders instead of sitting on a rail
                send_op(REQ_SETLEN, ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                                 : 12'($urandom_range(0, 90)));
            else if (pick < 87)
                send_op(REQ_PUSH, 12'($urandom));
            else if (pick < 97)
                send_op(REQ_POP, 12'($urandom));
            else if (pick < 99)
                send_op(3'($urandom_range(6, 7)), 12'($urandom));
            else
                // burst of pops that outruns the saves
                repeat ($urandom_range(2, 8)) send_op(REQ_POP, 12'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // opening: every command, field extremes, empty pop, unused codes
        send_op(REQ_POP, 12'd0);
        send_word(REQ_DRAW, 16'h0000, 12'h000, 24'h000000, 8'd1);
        send_word(REQ_DRAW, 16'hffff, 12'hfff, 24'hffffff, 8'd255);
        send_op(REQ_MOVE, 12'hfff);
        send_word(REQ_TURN, 16'h7fff, 12'h000, 24'h000000, 8'd1);
        send_op(REQ_DRAW, 12'd0);
        send_word(REQ_TURN, 16'h8000, 12'hfff, 24'hffffff, 8'd255);
        send_op(REQ_DRAW, 12'd0);
        send_op(REQ_SETLEN, 12'hfff);
        send_op(REQ_DRAW, 12'd0);
        send_op(REQ_SETLEN, 12'h000);
        send_op(REQ_DRAW, 12'd0);
        send_op(REQ_MOVE, 12'd0);
        send_op(REQ_SETLEN, 12'd37);
        send_op(REQ_PUSH, 12'd0);
        send_word(REQ_TURN, 16'h4000, 12'd0, 24'h5a5a5a, 8'd7);
        send_op(REQ_DRAW, 12'd0);
        send_op(REQ_POP, 12'd0);
        send_op(REQ_DRAW, 12'd0);
        send_op(3'd6, 12'hfff);
        send_op(3'd7, 12'hfff);
        send_word(REQ_TURN, 16'h0001, 12'd0, 24'd0, 8'd1);
        send_op(REQ_DRAW, 12'd0);
        send_op(REQ_PUSH, 12'd0);
        send_op(REQ_POP, 12'd0);
        send_op(REQ_POP, 12'd0);

        // fill the stack past full, then unwind past empty
        settle();
        repeat (STACK_LIMIT - tracker.depth + 2)
        begin
            send_op(REQ_PUSH, 12'd0);
            send_op(REQ_TURN, 12'd0);
            send_op(REQ_DRAW, 12'd0);
        end
        repeat (STACK_LIMIT + 2)
        begin
            send_op(REQ_POP, 12'd0);
            send_op(REQ_DRAW, 12'd0);
        end

        // corner start with the longest step, so steps clip
        settle();
        program_start(16'h7fff, 16'h8000, 12'hfff);
        random_run(200);

        settle();
        program_start(16'($urandom), 16'($urandom), 12'($urandom_range(0, 200)));
        random_run(450);

        settle();
        program_start(16'h8000, 16'h7fff, 12'h000);
        random_run(150);

        // last stretch runs flat out on both sides
        settle();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        quiet     = 1'b1;
        program_start(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                      12'($urandom_range(1, 60)));
        random_run(300);

        settle();
        repeat (12) @(posedge clk);
        tracker.finish_up();

        $display("ran %0d commands: %0d draws, %0d clipped steps, %0d full pushes, %0d empty pops",
                 tracker.words_noted, tracker.draws, tracker.clipped,
                 tracker.full_pushes, tracker.empty_pops);
        $display("checked %0d result words over five start settings, %0d mismatches",
                 tracker.words_checked, tracker.errors);
        if (tracker.errors == 0)
            $display("turtle_command_engine test passed");
        else
            $display("turtle_command_engine test failed");
        $finish;
    end

endmodule
